@@ design/g6_pkg.sv @@
// Shared types, constants and helpers for the graph6 adjacency store.
// No dependencies; compile first.
package g6_pkg;

  localparam int MAX_NODES = 16;
  localparam int NODE_CAP  = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam logic [4:0] NODE_LIMIT = 5'(NODE_CAP);

  localparam logic [7:0] CHAR_BASE = 8'd63;
  localparam logic [7:0] CHAR_TOP  = 8'd126;
  localparam int BITS_PER_CHAR = 6;
  localparam logic [2:0] LAST_BIT_IDX = 3'(BITS_PER_CHAR - 1);

  typedef enum logic [2:0] {
    MODE_HEADER  = 3'd0,
    MODE_BODY    = 3'd1,
    MODE_ADD_V   = 3'd2,
    MODE_DEL_V   = 3'd3,
    MODE_ADD_E   = 3'd4,
    MODE_DEL_E   = 3'd5,
    MODE_QUERY   = 3'd6
  } g6_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BODY,
    ST_RESULT
  } g6_state_t;

  // controller -> datapath
  typedef struct packed {
    logic       latch;        // capture the accepted transaction
    logic       exec;         // carry out the latched operation
    logic       bit_step;     // consume one body bit
    logic [2:0] bit_idx;      // which bit of the six, MSB first
    logic       result_load;  // fill the output register
  } g6_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic body_go;   // latched item is a well-formed body char
    logic running;   // a graph6 load is in progress
    logic out_free;  // output register can take a result this cycle
  } g6_status_t;

  function automatic logic [4:0] g6_popcount(input logic [15:0] x);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      n = n + 5'(x[i]);
    end
    return n;
  endfunction

endpackage

@@ design/g6_stream_if.sv @@
// Valid/ready channel interfaces for the graph6 adjacency store:
// request channel (operation in) and response channel (result out). No dependencies.
interface g6_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] text_char;
  logic [3:0] vertex_a;
  logic [3:0] vertex_b;

  modport source(output valid, mode, text_char, vertex_a, vertex_b, input ready);
  modport sink(input valid, mode, text_char, vertex_a, vertex_b, output ready);
endinterface

interface g6_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] vertex_mask;
  logic [4:0]  vertex_count;
  logic [6:0]  edge_count;
  logic        edge_present;
  logic [3:0]  degree_of_a;
  logic [15:0] neighbours_of_a;
  logic        bad_input;

  modport source(output valid, vertex_mask, vertex_count, edge_count, edge_present,
                 degree_of_a, neighbours_of_a, bad_input, input ready);
  modport sink(input valid, vertex_mask, vertex_count, edge_count, edge_present,
               degree_of_a, neighbours_of_a, bad_input, output ready);
endinterface

@@ design/g6_ctrl.sv @@
// Sequencer for the graph6 adjacency store: accept, execute, body bit steps, result.
// Depends on g6_pkg.
module g6_ctrl import g6_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  g6_status_t status,
  output g6_cmd_t    cmd
);

  g6_state_t  state, state_next;
  logic [2:0] bit_idx, bit_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_idx <= '0;
    end else begin
      state   <= state_next;
      bit_idx <= bit_idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    bit_idx_next = bit_idx;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.bit_idx  = bit_idx;
    case (state)
      ST_IDLE: begin
        // nothing is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.body_go) begin
          bit_idx_next = LAST_BIT_IDX;
          state_next   = ST_BODY;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_BODY: begin
        // one pair per cycle; a finished load skips the remaining bits
        cmd.bit_step = status.running;
        if (!status.running || bit_idx == '0) begin
          state_next = ST_RESULT;
        end else begin
          bit_idx_next = bit_idx - 3'd1;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_step_only_when_running: assert property (@(posedge clk) disable iff (rst)
    cmd.bit_step |-> status.running)
    else $error("body bit step issued with no load running");

  a_result_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |-> status.out_free)
    else $error("result loaded over an untaken result");

  a_accept_leads_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> cmd.exec)
    else $error("accepted transaction not executed next cycle");

endmodule

@@ design/g6_datapath.sv @@
// Datapath of the graph6 adjacency store: 16x16 flop matrix, vertex mask, edge
// count, graph6 load cursor and the output register. Depends on g6_pkg.
module g6_datapath import g6_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  g6_cmd_t     cmd,
  output g6_status_t  status,
  input  logic [2:0]  mode,
  input  logic [7:0]  text_char,
  input  logic [3:0]  vertex_a,
  input  logic [3:0]  vertex_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] vertex_mask,
  output logic [4:0]  vertex_count,
  output logic [6:0]  edge_count,
  output logic        edge_present,
  output logic [3:0]  degree_of_a,
  output logic [15:0] neighbours_of_a,
  output logic        bad_input
);

  // graph state
  logic [15:0] rows [16];
  logic [15:0] rows_next [16];
  logic [15:0] present, present_next;
  logic [6:0]  edge_total, edge_total_next;
  logic [3:0]  load_column, load_column_next;
  logic [3:0]  load_row, load_row_next;
  logic [4:0]  load_order, load_order_next;
  logic        load_running, load_running_next;

  // latched transaction
  logic [2:0] mode_q;
  logic [7:0] char_q;
  logic [3:0] a_q, b_q;
  logic       bad, bad_next;

  logic       char_ok;
  logic [7:0] char_off;
  logic [5:0] char_val;

  // shared edge update port
  logic       e_set, e_clr;
  logic [3:0] eu, ev;
  logic       e_in_range;

  logic [4:0] row_inc, col_inc;
  logic [4:0] del_count;

  assign char_ok  = (char_q >= CHAR_BASE) && (char_q <= CHAR_TOP);
  assign char_off = char_q - CHAR_BASE;
  assign char_val = char_off[5:0];
  assign row_inc  = {1'b0, load_row} + 5'd1;
  assign col_inc  = {1'b0, load_column} + 5'd1;
  assign del_count = g6_popcount(rows[a_q]);
  assign e_in_range = (eu != ev) && ({1'b0, eu} < NODE_LIMIT) && ({1'b0, ev} < NODE_LIMIT);

  assign status.body_go  = (mode_q == MODE_BODY) && char_ok;
  assign status.running  = load_running;
  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    rows_next         = rows;
    present_next      = present;
    edge_total_next   = edge_total;
    load_column_next  = load_column;
    load_row_next     = load_row;
    load_order_next   = load_order;
    load_running_next = load_running;
    bad_next          = bad;
    e_set = 1'b0;
    e_clr = 1'b0;
    eu    = a_q;
    ev    = b_q;

    if (cmd.latch) begin
      bad_next = 1'b0;
    end

    if (cmd.exec) begin
      case (mode_q)
        MODE_HEADER: begin
          load_running_next = 1'b0;
          load_column_next  = 4'd1;
          load_row_next     = '0;
          if (!char_ok || char_val > 6'(NODE_CAP)) begin
            bad_next = 1'b1;
          end else begin
            load_order_next = char_val[4:0];
            for (int i = 0; i < 16; i++) begin
              rows_next[i] = '0;
            end
            present_next      = 16'((17'd1 << char_val[4:0]) - 17'd1);
            edge_total_next   = '0;
            load_running_next = (char_val[4:0] >= 5'd2);
          end
        end
        MODE_BODY: begin
          if (!char_ok) begin
            bad_next = 1'b1;
          end
        end
        MODE_ADD_V: begin
          if ({1'b0, a_q} < NODE_LIMIT) begin
            present_next[a_q] = 1'b1;
          end
        end
        MODE_DEL_V: begin
          if ({1'b0, a_q} < NODE_LIMIT) begin
            for (int i = 0; i < 16; i++) begin
              rows_next[i][a_q] = 1'b0;
            end
            rows_next[a_q]    = '0;
            edge_total_next   = edge_total - 7'(del_count);
            present_next[a_q] = 1'b0;
          end
        end
        MODE_ADD_E: e_set = 1'b1;
        MODE_DEL_E: e_clr = 1'b1;
        default: begin
        end
      endcase
    end

    if (cmd.bit_step) begin
      eu    = load_row;
      ev    = load_column;
      e_set = char_val[cmd.bit_idx];
      if (row_inc >= {1'b0, load_column}) begin
        load_row_next = '0;
        if (col_inc >= load_order) begin
          load_running_next = 1'b0;
          load_column_next  = 4'd1;
        end else begin
          load_column_next = col_inc[3:0];
        end
      end else begin
        load_row_next = row_inc[3:0];
      end
    end

    if (e_set && e_in_range && !rows[eu][ev]) begin
      rows_next[eu][ev] = 1'b1;
      rows_next[ev][eu] = 1'b1;
      edge_total_next   = edge_total + 7'd1;
    end
    if (e_clr && e_in_range && rows[eu][ev]) begin
      rows_next[eu][ev] = 1'b0;
      rows_next[ev][eu] = 1'b0;
      edge_total_next   = edge_total - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        rows[i] <= '0;
      end
      present      <= '0;
      edge_total   <= '0;
      load_column  <= 4'd1;
      load_row     <= '0;
      load_order   <= '0;
      load_running <= 1'b0;
      bad          <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      rows         <= rows_next;
      present      <= present_next;
      edge_total   <= edge_total_next;
      load_column  <= load_column_next;
      load_row     <= load_row_next;
      load_order   <= load_order_next;
      load_running <= load_running_next;
      bad          <= bad_next;
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q <= mode;
      char_q <= text_char;
      a_q    <= vertex_a;
      b_q    <= vertex_b;
    end
    if (cmd.result_load) begin
      vertex_mask     <= present;
      vertex_count    <= g6_popcount(present);
      edge_count      <= edge_total;
      edge_present    <= (a_q != b_q) && rows[a_q][b_q];
      degree_of_a     <= 4'(g6_popcount(rows[a_q]));
      neighbours_of_a <= rows[a_q];
      bad_input       <= bad;
    end
  end

  a_result_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.result_load |=> out_valid)
    else $error("result load did not raise out_valid");

  a_cursor_order: assert property (@(posedge clk) disable iff (rst)
    load_running |-> (load_row < load_column) && ({1'b0, load_column} < load_order))
    else $error("graph6 load cursor out of order");

  a_no_self_loop: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !rows[a_q][a_q])
    else $error("self-loop stored in the matrix");

endmodule

@@ design/graph6_adjacency_store.sv @@
// Graph6 adjacency store: holds an undirected simple graph of up to 16 vertices as a
// symmetric 16x16 flop matrix plus a vertex mask and an edge count, and loads graph6
// text one character per transaction. Each request transaction gives one response
// transaction. Timing: the block takes a request when its sequencer is idle, executes it
// and then loads the output register, so edits, queries, header characters and rejected
// characters pass through only those steps; a well-formed graph6 body character also
// consumes its pair bits, one per cycle, between execution and the result load, plus a
// body step that consumes no bit when it consumes fewer than six (the load ends inside
// the character or no load is running). The bit-per-cycle figure comes
// from the single shared edge-update port of the matrix. A finished response sits in
// the output register while the next request is accepted; if it is still untaken
// when the next result is ready, the sequencer waits in its result step.
// Depends on g6_pkg, g6_stream_if, g6_ctrl and g6_datapath.
module graph6_adjacency_store import g6_pkg::*; (
  input logic     clk,
  input logic     rst,
  g6_req_if.sink  req,
  g6_rsp_if.source rsp
);

  g6_cmd_t    cmd;      // sequencer commands to the datapath
  g6_status_t status;   // datapath flags back to the sequencer

  // Sequencer: owns request-side ready and steps body characters bit by bit.
  g6_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: matrix, counters, load cursor and the response register.
  g6_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .mode            (req.mode),
    .text_char       (req.text_char),
    .vertex_a        (req.vertex_a),
    .vertex_b        (req.vertex_b),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .vertex_mask     (rsp.vertex_mask),
    .vertex_count    (rsp.vertex_count),
    .edge_count      (rsp.edge_count),
    .edge_present    (rsp.edge_present),
    .degree_of_a     (rsp.degree_of_a),
    .neighbours_of_a (rsp.neighbours_of_a),
    .bad_input       (rsp.bad_input)
  );

endmodule

@@ verif/graph6_adjacency_store_test.sv @@
// Self-checking testbench for graph6_adjacency_store: directed and random traffic on
// the request channel, each response checked against an in-bench graph predictor.
// Depends on g6_pkg, g6_stream_if and the graph6_adjacency_store RTL.
`timescale 1ns / 1ps

module graph6_adjacency_store_test;
  import g6_pkg::*;

  // Mode code 7 is outside the enum; the block treats it as a query.
  localparam logic [2:0] MODE_SPARE = 3'd7;
  // Worst case is a body char: latch, execute, six bit steps, result load.
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 150;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] text_char;
    logic [3:0] vertex_a;
    logic [3:0] vertex_b;
  } graph_op_t;

  // Field order matches the concatenation used in the response checker.
  typedef struct packed {
    logic [15:0] vertex_mask;
    logic [4:0]  vertex_count;
    logic [6:0]  edge_count;
    logic        edge_present;
    logic [3:0]  degree_of_a;
    logic [15:0] neighbours_of_a;
    logic        bad_input;
  } graph_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  g6_req_if req();
  g6_rsp_if rsp();

  graph6_adjacency_store i_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Graph predictor: its own copy of the matrix, the present mask, the edge
  // total and the graph6 load position.
  // ---------------------------------------------------------------------------
  logic [15:0] adj_rows [16];
  logic [15:0] present_vs;
  logic [6:0]  edge_tot;
  int          load_col;
  int          load_row;
  int          load_len;
  bit          load_on;

  graph_view_t expected_views[$];
  int          mismatch_total = 0;
  int          ops_sent = 0;

  // Idle controls, switched per phase by the test tasks.
  bit sender_gaps_on = 1'b1;
  bit receiver_stalls_on = 1'b1;
  int rsp_hold_cycles = 0;

  function automatic void end_load();
    load_on  = 1'b0;
    load_col = 1;
    load_row = 0;
  endfunction

  // Edges are a set: self-loops, duplicates and missing edges change nothing.
  function automatic void link_pair(int u, int v);
    if (u == v || u >= NODE_CAP || v >= NODE_CAP) return;
    if (adj_rows[u][v]) return;
    adj_rows[u][v] = 1'b1;
    adj_rows[v][u] = 1'b1;
    edge_tot = edge_tot + 7'd1;
  endfunction

  function automatic void unlink_pair(int u, int v);
    if (u == v || u >= NODE_CAP || v >= NODE_CAP) return;
    if (!adj_rows[u][v]) return;
    adj_rows[u][v] = 1'b0;
    adj_rows[v][u] = 1'b0;
    edge_tot = edge_tot - 7'd1;
  endfunction

  function automatic void clear_graph();
    foreach (adj_rows[i]) adj_rows[i] = '0;
    present_vs = '0;
    edge_tot   = '0;
    load_len   = 0;
    end_load();
  endfunction

  // Applies one transaction to the predictor and returns the response it must give.
  function automatic graph_view_t graph_apply(input graph_op_t op);
    graph_view_t v;
    bit          char_ok;
    int          code;
    v = '0;
    char_ok = op.text_char >= CHAR_BASE && op.text_char <= CHAR_TOP;
    code = int'(op.text_char) - int'(CHAR_BASE);
    case (op.mode)
      MODE_HEADER: begin
        // bad char or count above the node cap: graph kept, load stopped
        if (!char_ok || code > NODE_CAP) begin
          v.bad_input = 1'b1;
          end_load();
        end else begin
          load_len = code;
          foreach (adj_rows[i]) adj_rows[i] = '0;
          present_vs = 16'((32'd1 << load_len) - 32'd1);
          edge_tot = '0;
          end_load();
          load_on = (load_len >= 2);
        end
      end
      MODE_BODY: begin
        // a rejected body char keeps the load position
        if (!char_ok) begin
          v.bad_input = 1'b1;
        end else begin
          for (int k = BITS_PER_CHAR - 1; k >= 0 && load_on; k--) begin
            if (code[k]) link_pair(load_row, load_col);
            load_row++;
            if (load_row >= load_col) begin
              load_row = 0;
              load_col++;
              if (load_col >= load_len) end_load();
            end
          end
        end
      end
      MODE_ADD_V: begin
        if (op.vertex_a < NODE_CAP) present_vs[op.vertex_a] = 1'b1;
      end
      MODE_DEL_V: begin
        if (op.vertex_a < NODE_CAP) begin
          for (int i = 0; i < 16; i++) unlink_pair(int'(op.vertex_a), i);
          present_vs[op.vertex_a] = 1'b0;
        end
      end
      MODE_ADD_E: link_pair(int'(op.vertex_a), int'(op.vertex_b));
      MODE_DEL_E: unlink_pair(int'(op.vertex_a), int'(op.vertex_b));
      default: ;
    endcase
    v.vertex_mask     = present_vs;
    v.vertex_count    = 5'($countones(present_vs));
    v.edge_count      = edge_tot;
    v.edge_present    = (op.vertex_a != op.vertex_b) ? adj_rows[op.vertex_a][op.vertex_b] : 1'b0;
    v.degree_of_a     = 4'($countones(adj_rows[op.vertex_a]));
    v.neighbours_of_a = adj_rows[op.vertex_a];
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: one transaction at a time, valid held until accepted.
  // ---------------------------------------------------------------------------
  task automatic offer_op(input logic [2:0] mode, input logic [7:0] ch,
                          input logic [3:0] a, input logic [3:0] b);
    graph_op_t op;
    op = '{mode: mode, text_char: ch, vertex_a: a, vertex_b: b};
    req.valid     <= 1'b1;
    req.mode      <= mode;
    req.text_char <= ch;
    req.vertex_a  <= a;
    req.vertex_b  <= b;
    do @(posedge clk); while (req.ready !== 1'b1);
    // accepted at this edge: predict now, in acceptance order
    expected_views.push_back(graph_apply(op));
    ops_sent++;
    if (sender_gaps_on && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Sender pause: nothing offered until every expected response has come back.
  task automatic drain_responses();
    req.valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [3:0] any_vertex();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [7:0] bad_char();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, CHAR_BASE - 1));
    return 8'($urandom_range(CHAR_TOP + 1, 255));
  endfunction

  function automatic logic [7:0] body_char();
    case ($urandom_range(0, 7))
      0: return CHAR_BASE;
      1: return CHAR_TOP;
      default: return 8'($urandom_range(CHAR_BASE, CHAR_TOP));
    endcase
  endfunction

  // Either an illegal char or a count above the node cap.
  function automatic logic [7:0] bad_header_char();
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(CHAR_BASE + 17, CHAR_TOP));
    return bad_char();
  endfunction

  // One edit or query on vertices 0..vmax; text_char is don't-care here but toggled.
  task automatic random_edit(input int vmax);
    logic [2:0] m;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6: m = MODE_ADD_E;
      7, 8, 9, 10:         m = MODE_DEL_E;
      11, 12:              m = MODE_ADD_V;
      13:                  m = MODE_DEL_V;
      14:                  m = MODE_SPARE;
      default:             m = MODE_QUERY;
    endcase
    offer_op(m, 8'($urandom_range(0, 255)), 4'($urandom_range(0, vmax)),
             4'($urandom_range(0, vmax)));
  endtask

  // Header plus the full body for n vertices, then one to three edits unless the load is
  // abandoned. With noise, rejected chars, edits mid-load and abandoned loads are mixed in.
  task automatic load_random_graph(input int n, input bit with_noise);
    int body_len;
    body_len = (n * (n - 1) / 2 + 5) / 6;
    offer_op(MODE_HEADER, 8'(CHAR_BASE + n), any_vertex(), any_vertex());
    for (int c = 0; c < body_len; c++) begin
      if (with_noise) begin
        case ($urandom_range(0, 24))
          0: offer_op(MODE_BODY, bad_char(), any_vertex(), any_vertex());
          1: random_edit(n - 1);
          2: return;
          3: begin
            offer_op(MODE_HEADER, bad_header_char(), any_vertex(), any_vertex());
            return;
          end
          default: ;
        endcase
      end
      offer_op(MODE_BODY, body_char(), any_vertex(), any_vertex());
    end
    repeat ($urandom_range(1, 3)) random_edit(n - 1);
  endtask

  function automatic int pick_order();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom_range(8, 15);
      2:       return 16;
      default: return $urandom_range(2, 7);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------------
  task automatic test_directed_cases();
    offer_op(MODE_QUERY, 8'h00, 4'd0, 4'd15);                 // empty store
    offer_op(MODE_HEADER, 8'(CHAR_BASE + 4), 4'd0, 4'd1);     // four vertices
    offer_op(MODE_BODY, CHAR_TOP, 4'd0, 4'd3);                // all six pairs: K4
    offer_op(MODE_BODY, CHAR_TOP, 4'd3, 4'd2);                // no load running: ignored
    offer_op(MODE_HEADER, 8'(CHAR_BASE + 17), 4'd1, 4'd2);    // count above cap
    offer_op(MODE_HEADER, 8'(CHAR_TOP + 1), 4'd1, 4'd2);      // char above range
    offer_op(MODE_HEADER, 8'(CHAR_BASE - 1), 4'd1, 4'd2);     // char below range
    offer_op(MODE_HEADER, 8'hFF, 4'd2, 4'd3);
    offer_op(MODE_HEADER, 8'h00, 4'd2, 4'd3);
    offer_op(MODE_HEADER, CHAR_BASE, 4'd0, 4'd1);             // zero vertices
    offer_op(MODE_HEADER, 8'(CHAR_BASE + 1), 4'd0, 4'd1);     // one vertex, no pairs
    offer_op(MODE_HEADER, 8'(CHAR_BASE + 16), 4'd15, 4'd0);   // all sixteen present
    offer_op(MODE_HEADER, 8'(CHAR_BASE + 5), 4'd0, 4'd4);     // ten pairs, two chars
    offer_op(MODE_BODY, CHAR_TOP, 4'd0, 4'd3);
    offer_op(MODE_BODY, 8'h00, 4'd0, 4'd4);                   // rejected, keeps place
    offer_op(MODE_BODY, 8'hFF, 4'd1, 4'd4);                   // rejected, keeps place
    offer_op(MODE_BODY, 8'(CHAR_BASE + 6'b011011), 4'd2, 4'd4); // last pairs + padding
    offer_op(MODE_SPARE, 8'h55, 4'd1, 4'd2);                  // code 7 behaves as query
    offer_op(MODE_ADD_V, 8'hAA, 4'd15, 4'd0);
    offer_op(MODE_ADD_V, 8'h00, 4'd0, 4'd15);                 // already present
    offer_op(MODE_ADD_E, 8'h00, 4'd0, 4'd15);
    offer_op(MODE_ADD_E, 8'h00, 4'd15, 4'd0);                 // duplicate
    offer_op(MODE_ADD_E, 8'h00, 4'd3, 4'd3);                  // self-loop
    offer_op(MODE_ADD_E, 8'h00, 4'd12, 4'd13);                // both ends absent, still counted
    offer_op(MODE_DEL_E, 8'h00, 4'd5, 4'd14);                 // nothing to delete
    offer_op(MODE_DEL_V, 8'h00, 4'd0, 4'd15);                 // clears row and column 0
    offer_op(MODE_DEL_E, 8'h00, 4'd2, 4'd1);
  endtask

  // Mostly well-formed graph6 text with random content, some broken sequences.
  task automatic test_graph6_loads();
    int stop_at;
    stop_at = ops_sent + 450;
    while (ops_sent < stop_at) begin
      sender_gaps_on     = $urandom_range(0, 3) != 0;
      receiver_stalls_on = $urandom_range(0, 3) != 0;
      load_random_graph(pick_order(), $urandom_range(0, 2) != 0);
    end
  endtask

  // Edits on a complete sixteen-vertex graph, narrow and wide vertex ranges.
  task automatic test_graph_edits();
    int vmax;
    offer_op(MODE_HEADER, 8'(CHAR_BASE + 16), any_vertex(), any_vertex());
    repeat (20) offer_op(MODE_BODY, CHAR_TOP, any_vertex(), any_vertex());
    for (int chunk = 0; chunk < 10; chunk++) begin
      case ($urandom_range(0, 2))
        0:       vmax = 3;
        1:       vmax = 7;
        default: vmax = 15;
      endcase
      sender_gaps_on     = chunk % 3 != 0;
      receiver_stalls_on = chunk % 4 != 1;
      repeat (25) random_edit(vmax);
    end
  endtask

  // Response side held off while requests keep coming, so the block stalls its input.
  task automatic test_output_backpressure();
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    rsp_hold_cycles    = HOLD_OFF_CYCLES;
    repeat (30) random_edit(15);
    load_random_graph(6, 1'b0);
    drain_responses();
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
  endtask

  // Any mode (7 included), any char, any vertices.
  task automatic test_random_noise();
    repeat (150) begin
      offer_op(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), any_vertex(),
               any_vertex());
    end
  endtask

  // Closing stretch at full rate: no idling on either side.
  task automatic test_steady_stream();
    int stop_at;
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    stop_at = ops_sent + 150;
    while (ops_sent < stop_at) begin
      if ($urandom_range(0, 1) == 0) load_random_graph(pick_order(), 1'b1);
      else repeat (10) random_edit(15);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random ready stalls, plus the long hold-off counted here.
  // ---------------------------------------------------------------------------
  initial begin : rsp_ready_driver
    int stall_left;
    stall_left = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_hold_cycles > 0) begin
        rsp.ready <= 1'b0;
        rsp_hold_cycles--;
      end else if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else if (receiver_stalls_on && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        stall_left = $urandom_range(1, 17) - 1;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatch_total++;
    end
  endtask

  // Every response transaction is compared against the oldest prediction.
  always @(posedge clk) begin : result_checker
    graph_view_t want;
    graph_view_t got;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      got = {rsp.vertex_mask, rsp.vertex_count, rsp.edge_count, rsp.edge_present,
             rsp.degree_of_a, rsp.neighbours_of_a, rsp.bad_input};
      if (expected_views.size() == 0) begin
        $display("%0t: response with none expected, got 0x%0h", $time, got);
        mismatch_total++;
      end else begin
        want = expected_views.pop_front();
        check_field("vertex_mask", want.vertex_mask, got.vertex_mask);
        check_field("vertex_count", 16'(want.vertex_count), 16'(got.vertex_count));
        check_field("edge_count", 16'(want.edge_count), 16'(got.edge_count));
        check_field("edge_present", 16'(want.edge_present), 16'(got.edge_present));
        check_field("degree_of_a", 16'(want.degree_of_a), 16'(got.degree_of_a));
        check_field("neighbours_of_a", want.neighbours_of_a, got.neighbours_of_a);
        check_field("bad_input", 16'(want.bad_input), 16'(got.bad_input));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : test_sequence
    req.valid     = 1'b0;
    req.mode      = MODE_QUERY;
    req.text_char = '0;
    req.vertex_a  = '0;
    req.vertex_b  = '0;
    clear_graph();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_graph6_loads();
    test_output_backpressure();
    test_graph_edits();
    test_random_noise();
    test_steady_stream();

    // all expected responses in, then a settling wait to catch strays
    drain_responses();
    if (mismatch_total == 0) begin
      $display("graph6_adjacency_store: match");
    end else begin
      $display("graph6_adjacency_store: mismatch");
    end
    $finish;
  end

  // Run limit, several times the slowest legal run.
  initial begin : run_limit
    #5_000_000;
    $display("graph6_adjacency_store: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
design/g6_pkg.sv
design/g6_stream_if.sv
design/g6_ctrl.sv
design/g6_datapath.sv
design/graph6_adjacency_store.sv
verif/graph6_adjacency_store_test.sv
